// ===== src/bdar_pkg.sv =====
// ----------------------------------------------------------------------------
// bdar_pkg - shared types and constants of the button debounce/repeat unit
// Phase codes, register indexes, reset values and the slot flag struct.
// ----------------------------------------------------------------------------
package bdar_pkg;

   // Buttons per controller, fixed by the raw input layout
   localparam int BUTTONS = 8;
   localparam int BTN_BITS = 3;
   // Controllers that the input fields can describe
   localparam int MAX_INPUT_PADS = 4;

   localparam int CT_BITS = 9;
   localparam int DELAY_BITS = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEBOUNCE      = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_DLY_LOW  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_DLY_HIGH = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REP_DLY_LOW   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REP_DLY_HIGH  = 3'd4;

   // Configuration reset values
   localparam logic [7:0]  RST_DEBOUNCE      = 8'd20;
   localparam logic [63:0] RST_INIT_DLY_LOW  = 64'd32768500;
   localparam logic [63:0] RST_INIT_DLY_HIGH = 64'd56297142838886500;
   localparam logic [63:0] RST_REP_DLY_LOW   = 64'd32768500;
   localparam logic [63:0] RST_REP_DLY_HIGH  = 64'd5629628384542770;

   // Per-button phase
   typedef enum logic [1:0] {
      PH_RELEASED = 2'd0,
      PH_NEW      = 2'd1,
      PH_ONCE     = 2'd2,
      PH_REPEAT   = 2'd3
   } bdar_phase_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_LOAD  = 3'd1,
      ST_CALC  = 3'd2,
      ST_SCAN  = 3'd3,
      ST_FLUSH = 3'd4
   } bdar_state_type;

   // Event flags from the slot update unit
   typedef struct packed {
      logic release_evt;
      logic press_evt;
   } bdar_slot_flags_type;

endpackage

// ===== src/bdar_req_if.sv =====
// ----------------------------------------------------------------------------
// bdar_req_if - poll channel
// Carries one poll: timestamp, raw button bits and controller presence.
// ----------------------------------------------------------------------------
interface bdar_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [31:0] raw_pressed;
   logic [3:0]  connected;

   modport source (output valid, output now_ms, output raw_pressed, output connected,
                   input ready);
   modport sink   (input valid, input now_ms, input raw_pressed, input connected,
                   output ready);
endinterface

// ===== src/bdar_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bdar_rsp_if - event channel
// Carries one button event per transfer.
// ----------------------------------------------------------------------------
interface bdar_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] pad_index;
   logic [2:0] button_index;
   logic       is_release;
   logic       last_event;

   modport source (output valid, output pad_index, output button_index,
                   output is_release, output last_event, input ready);
   modport sink   (input valid, input pad_index, input button_index,
                   input is_release, input last_event, output ready);
endinterface

// ===== src/bdar_ram.sv =====
// ----------------------------------------------------------------------------
// bdar_ram - generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bdar_slot_unit.sv =====
// ----------------------------------------------------------------------------
// bdar_slot_unit - shared per-button update unit
// Advances one button's timers, applies debounce and decides release and
// press/repeat events for the current poll.
// ----------------------------------------------------------------------------
module bdar_slot_unit #(
   parameter int TIMER_BITS = 20
) (
   input  bdar_pkg::bdar_phase_type          phase_old,
   input  logic [bdar_pkg::CT_BITS-1:0]      ct_old,
   input  logic [TIMER_BITS-1:0]             rt_old,
   input  logic [31:0]                       delta,
   input  logic [7:0]                        debounce,
   input  logic                              now_pressed,
   input  logic [bdar_pkg::DELAY_BITS-1:0]   first_delay,
   input  logic [bdar_pkg::DELAY_BITS-1:0]   later_delay,
   output bdar_pkg::bdar_phase_type          phase_new,
   output logic [bdar_pkg::CT_BITS-1:0]      ct_new,
   output logic [TIMER_BITS-1:0]             rt_new,
   output bdar_pkg::bdar_slot_flags_type     flags
);

   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic [32:0]                  ct_sum;
   logic [32:0]                  rt_sum;
   logic [bdar_pkg::CT_BITS-1:0] limit;
   logic [bdar_pkg::CT_BITS-1:0] ct_sat;
   logic [TIMER_BITS-1:0]        rt_sat;
   logic                         change;
   bdar_pkg::bdar_phase_type     phase_mid;
   logic [TIMER_BITS-1:0]        rt_mid;
   logic [TIMER_BITS-1:0]        first_ext;
   logic [TIMER_BITS-1:0]        later_ext;
   logic                         release_hit;
   logic                         press_hit;

   // Advance and saturate both timers
   always_comb begin
      limit  = bdar_pkg::CT_BITS'(debounce) + 9'd1;
      ct_sum = 33'(ct_old) + 33'(delta);
      rt_sum = 33'(rt_old) + 33'(delta);
      ct_sat = (ct_sum > 33'(limit)) ? limit : ct_sum[bdar_pkg::CT_BITS-1:0];
      rt_sat = (rt_sum > 33'(TMAX)) ? TMAX : rt_sum[TIMER_BITS-1:0];
   end

   // Debounce: accept a state change once the change timer passes the threshold
   always_comb begin
      change = (now_pressed != (phase_old != bdar_pkg::PH_RELEASED)) &&
               (ct_sat > bdar_pkg::CT_BITS'(debounce));
      release_hit = change && !now_pressed;
      if (change) begin
         ct_new    = '0;
         rt_mid    = '0;
         phase_mid = now_pressed ? bdar_pkg::PH_NEW : bdar_pkg::PH_RELEASED;
      end else begin
         ct_new    = ct_sat;
         rt_mid    = rt_sat;
         phase_mid = phase_old;
      end
   end

   // Press and typematic repeat
   always_comb begin
      first_ext = TIMER_BITS'(first_delay);
      later_ext = TIMER_BITS'(later_delay);
      press_hit = 1'b0;
      phase_new = phase_mid;
      rt_new    = rt_mid;
      case (phase_mid)
         bdar_pkg::PH_NEW: begin
            press_hit = 1'b1;
            rt_new    = '0;
            phase_new = bdar_pkg::PH_ONCE;
         end
         bdar_pkg::PH_ONCE: begin
            if ((first_delay != '0) && (rt_mid >= first_ext)) begin
               press_hit = 1'b1;
               rt_new    = rt_mid - first_ext;
               phase_new = bdar_pkg::PH_REPEAT;
            end
         end
         bdar_pkg::PH_REPEAT: begin
            if ((later_delay != '0) && (rt_mid >= later_ext)) begin
               press_hit = 1'b1;
               rt_new    = rt_mid - later_ext;
            end
         end
         default: begin
            press_hit = 1'b0;
         end
      endcase
   end

   // Gather the event flags
   always_comb begin
      flags.release_evt = release_hit;
      flags.press_evt   = press_hit;
   end

endmodule

// ===== src/button_debounce_autorepeat_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_unit - key debounce with typematic repeat
// Walks every button of every controller once per poll through one shared
// update unit, then emits release events followed by press/repeat events.
// ----------------------------------------------------------------------------
//  channel  direction  transfer            payload
//  req_if   in         one poll            now_ms, raw_pressed, connected
//  rsp_if   out        one button event    pad_index, button_index,
//                                          is_release, last_event
//  csr_*    in         register write      csr_index, csr_wdata
//
// A poll runs, accept to accept: the idle state takes the poll, the load state
// starts the state RAM read, the release pass takes one button per cycle
// through the update unit and the press pass one button per cycle over the
// press flags while no event stalls, and the flush state sends the final event.
// Event backpressure stalls the walk in place. Button state resets through
// per-entry valid bits, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_unit #(
   parameter int PADS       = 4,
   parameter int TIMER_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bdar_req_if.sink                             req_if,
   bdar_rsp_if.source                           rsp_if,
   input  logic                                 csr_wr_en,
   input  logic [bdar_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [bdar_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int SLOTS = PADS * bdar_pkg::BUTTONS;
   localparam int SW    = $clog2(SLOTS);
   localparam int SCW   = SW + 1;
   localparam int WORD  = 2 + bdar_pkg::CT_BITS + TIMER_BITS;
   localparam logic [SCW-1:0] LAST_SLOT = SCW'(SLOTS - 1);

   // Configuration registers
   logic [7:0]  dbnc_ff;
   logic [63:0] init_lo_ff, init_hi_ff, rep_lo_ff, rep_hi_ff;

   // Poll registers
   logic [31:0] prev_ff, delta_ff, raw_ff;
   logic [3:0]  conn_ff;

   // Sequencer
   bdar_pkg::bdar_state_type state_ff, state_in;
   logic [SCW-1:0]   slot_ff, slot_in;
   logic [SLOTS-1:0] fire_ff, fire_in;
   logic [SLOTS-1:0] vld_ff, vld_in;

   // Pending event and output register
   logic       pend_valid_ff, pend_valid_in;
   logic [1:0] pend_pad_ff, pend_pad_in;
   logic [2:0] pend_btn_ff, pend_btn_in;
   logic       pend_rel_ff, pend_rel_in;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_pad_ff, out_pad_in;
   logic [2:0] out_btn_ff, out_btn_in;
   logic       out_rel_ff, out_rel_in;
   logic       out_last_ff, out_last_in;

   // Control
   logic          req_take;
   logic          out_free;
   logic          can_push;
   logic          advance;
   logic          evt_hit;
   logic          evt_rel;
   logic          flush_go;
   logic          ram_we;
   logic [SW-1:0] rd_addr;
   logic [SW-1:0] slot_idx;
   logic [2:0]    btn;
   logic [3:0]    pad_num;
   logic          now_pressed;

   // State RAM and slot unit signals
   logic [WORD-1:0]                  rd_word;
   logic [WORD-1:0]                  wr_word;
   bdar_pkg::bdar_phase_type         phase_old, phase_new;
   logic [bdar_pkg::CT_BITS-1:0]     ct_old, ct_new;
   logic [TIMER_BITS-1:0]            rt_old, rt_new;
   logic [63:0]                      first_word, later_word;
   logic [5:0]                       lane_base;
   logic [bdar_pkg::DELAY_BITS-1:0]  first_delay, later_delay;
   bdar_pkg::bdar_slot_flags_type    flags;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dbnc_ff    <= bdar_pkg::RST_DEBOUNCE;
         init_lo_ff <= bdar_pkg::RST_INIT_DLY_LOW;
         init_hi_ff <= bdar_pkg::RST_INIT_DLY_HIGH;
         rep_lo_ff  <= bdar_pkg::RST_REP_DLY_LOW;
         rep_hi_ff  <= bdar_pkg::RST_REP_DLY_HIGH;
      end else if (csr_wr_en) begin
         case (csr_index)
            bdar_pkg::CSR_DEBOUNCE:      dbnc_ff    <= csr_wdata[7:0];
            bdar_pkg::CSR_INIT_DLY_LOW:  init_lo_ff <= csr_wdata;
            bdar_pkg::CSR_INIT_DLY_HIGH: init_hi_ff <= csr_wdata;
            bdar_pkg::CSR_REP_DLY_LOW:   rep_lo_ff  <= csr_wdata;
            bdar_pkg::CSR_REP_DLY_HIGH:  rep_hi_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Latch the poll and the elapsed time
   assign req_take = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (req_take) begin
         prev_ff <= req_if.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         delta_ff <= req_if.now_ms - prev_ff;
         raw_ff   <= req_if.raw_pressed;
         conn_ff  <= req_if.connected;
      end
   end

   // Decode the current slot
   always_comb begin
      slot_idx    = slot_ff[SW-1:0];
      btn         = slot_ff[2:0];
      pad_num     = 4'(slot_ff[SCW-1:3]);
      now_pressed = (pad_num < 4'(bdar_pkg::MAX_INPUT_PADS)) && conn_ff[pad_num[1:0]] &&
                    raw_ff[{pad_num[1:0], btn}];
      lane_base   = {btn[1:0], 4'b0000};
      first_word  = btn[2] ? init_hi_ff : init_lo_ff;
      later_word  = btn[2] ? rep_hi_ff : rep_lo_ff;
      first_delay = first_word[lane_base +: bdar_pkg::DELAY_BITS];
      later_delay = later_word[lane_base +: bdar_pkg::DELAY_BITS];
   end

   // Unpack the stored word; an entry never written reads as reset state
   always_comb begin
      if (vld_ff[slot_idx]) begin
         phase_old = bdar_pkg::bdar_phase_type'(rd_word[WORD-1 -: 2]);
         ct_old    = rd_word[TIMER_BITS +: bdar_pkg::CT_BITS];
         rt_old    = rd_word[TIMER_BITS-1:0];
      end else begin
         phase_old = bdar_pkg::PH_RELEASED;
         ct_old    = '0;
         rt_old    = '0;
      end
      wr_word = {phase_new, ct_new, rt_new};
   end

   bdar_slot_unit #(
      .TIMER_BITS (TIMER_BITS)
   ) u_slot (
      .phase_old   (phase_old),
      .ct_old      (ct_old),
      .rt_old      (rt_old),
      .delta       (delta_ff),
      .debounce    (dbnc_ff),
      .now_pressed (now_pressed),
      .first_delay (first_delay),
      .later_delay (later_delay),
      .phase_new   (phase_new),
      .ct_new      (ct_new),
      .rt_new      (rt_new),
      .flags       (flags)
   );

   bdar_ram #(
      .WIDTH (WORD),
      .DEPTH (SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_idx),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdar_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = bdar_pkg::ST_LOAD;
            end
         end
         bdar_pkg::ST_LOAD: begin
            state_in = bdar_pkg::ST_CALC;
         end
         bdar_pkg::ST_CALC: begin
            if (advance && (slot_ff == LAST_SLOT)) begin
               state_in = bdar_pkg::ST_SCAN;
            end
         end
         bdar_pkg::ST_SCAN: begin
            if (advance && (slot_ff == LAST_SLOT)) begin
               state_in = bdar_pkg::ST_FLUSH;
            end
         end
         bdar_pkg::ST_FLUSH: begin
            if (flush_go) begin
               state_in = bdar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdar_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      out_free     = !out_valid_ff || rsp_if.ready;
      can_push     = !pend_valid_ff || out_free;
      req_if.ready = 1'b0;
      evt_hit      = 1'b0;
      evt_rel      = 1'b0;
      advance      = 1'b0;
      flush_go     = 1'b0;
      ram_we       = 1'b0;
      rd_addr      = slot_idx;
      case (state_ff)
         bdar_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         bdar_pkg::ST_LOAD: begin
            rd_addr = '0;
         end
         bdar_pkg::ST_CALC: begin
            evt_hit = flags.release_evt;
            evt_rel = 1'b1;
            advance = !flags.release_evt || can_push;
            ram_we  = advance;
            rd_addr = advance ? SW'(slot_ff + 1'b1) : slot_idx;
         end
         bdar_pkg::ST_SCAN: begin
            evt_hit = fire_ff[slot_idx];
            advance = !fire_ff[slot_idx] || can_push;
         end
         bdar_pkg::ST_FLUSH: begin
            flush_go = !pend_valid_ff || out_free;
         end
         default: begin
         end
      endcase
   end

   // Slot counter, press flags and valid bits
   always_comb begin
      slot_in = slot_ff;
      fire_in = fire_ff;
      vld_in  = vld_ff;
      if (state_ff == bdar_pkg::ST_LOAD) begin
         slot_in = '0;
      end else if (advance) begin
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         if (state_ff == bdar_pkg::ST_CALC) begin
            fire_in[slot_idx] = flags.press_evt;
            vld_in[slot_idx]  = 1'b1;
         end else begin
            fire_in[slot_idx] = 1'b0;
         end
      end
   end

   // Pending event and output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_pad_in   = pend_pad_ff;
      pend_btn_in   = pend_btn_ff;
      pend_rel_in   = pend_rel_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_pad_in    = out_pad_ff;
      out_btn_in    = out_btn_ff;
      out_rel_in    = out_rel_ff;
      out_last_in   = out_last_ff;
      if (advance && evt_hit) begin
         // Push the held event out, hold the new one until a later one shows
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_pad_in   = pend_pad_ff;
            out_btn_in   = pend_btn_ff;
            out_rel_in   = pend_rel_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_pad_in   = pad_num[1:0];
         pend_btn_in   = btn;
         pend_rel_in   = evt_rel;
      end else if (flush_go && pend_valid_ff) begin
         // Send the final event of the poll
         out_valid_in  = 1'b1;
         out_pad_in    = pend_pad_ff;
         out_btn_in    = pend_btn_ff;
         out_rel_in    = pend_rel_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bdar_pkg::ST_IDLE;
         slot_ff       <= '0;
         fire_ff       <= '0;
         vld_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         fire_ff       <= fire_in;
         vld_ff        <= vld_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pad_ff <= pend_pad_in;
      pend_btn_ff <= pend_btn_in;
      pend_rel_ff <= pend_rel_in;
      out_pad_ff  <= out_pad_in;
      out_btn_ff  <= out_btn_in;
      out_rel_ff  <= out_rel_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.pad_index    = out_pad_ff;
   assign rsp_if.button_index = out_btn_ff;
   assign rsp_if.is_release   = out_rel_ff;
   assign rsp_if.last_event   = out_last_ff;

   // No held event may survive into the next poll
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdar_pkg::ST_IDLE) |-> (!pend_valid_ff && (fire_ff == '0)))
      else $error("event left over at end of poll");

   // The walk never leaves the slot range
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bdar_pkg::ST_CALC) || (state_ff == bdar_pkg::ST_SCAN)) |->
      (slot_ff <= LAST_SLOT))
      else $error("slot counter out of range");

   // A flush with a held event marks the next output as the last of the poll
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bdar_pkg::ST_FLUSH) && pend_valid_ff && out_free) |=>
      (out_valid_ff && out_last_ff))
      else $error("final event not flagged");

   // Release events only come from the release pass
   a_release_pass: assert property (@(posedge clock) disable iff (reset)
      (advance && evt_hit && evt_rel) |-> (state_ff == bdar_pkg::ST_CALC))
      else $error("release event outside the release pass");

endmodule

// ===== tb/button_debounce_autorepeat_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_unit_tb - self-checking bench for the debounce unit
// Feeds polls through the request channel, predicts every button event with a
// behavioral copy of the debounce and repeat logic, and checks each event
// transfer in order. A short table covers the corner cases, then random
// polls run under several register settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_unit_tb;

   localparam int SLOTS = 32;
   // One poll walks every button twice, plus load and flush cycles
   localparam int POLL_CYCLES = 2 * SLOTS + 3;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam logic [32:0] REPEAT_TIMER_MAX = 33'h0_000F_FFFF;
   // Register indexes with no register behind them
   localparam logic [bdar_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [bdar_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [2:0] BTN_B    = 3'd0;
   localparam logic [2:0] BTN_LEFT = 3'd7;

   typedef struct packed {
      logic [1:0] pad;
      logic [2:0] btn;
      logic       rel;
      logic       last;
   } key_event_type;

   // How a directed row is checked
   typedef enum int {
      CHK_MODEL,
      CHK_QUIET,
      CHK_ONE
   } row_check_type;

   typedef struct {
      logic [31:0]   poll_ms;
      logic [31:0]   raw;
      logic [3:0]    conn;
      row_check_type chk;
      logic [1:0]    pad;
      logic [2:0]    btn;
      logic          rel;
   } poll_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [bdar_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [bdar_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   bdar_req_if req_ch ();
   bdar_rsp_if rsp_ch ();

   button_debounce_autorepeat_unit #(
      .PADS       (4),
      .TIMER_BITS (20)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted button state
   bdar_pkg::bdar_phase_type key_phase [SLOTS];
   logic [8:0]               settle_timer [SLOTS];
   logic [19:0]              rep_timer [SLOTS];
   logic [31:0]              last_poll_ms;

   // Predicted register contents
   logic [7:0]  cfg_debounce;
   logic [63:0] cfg_first_lo, cfg_first_hi, cfg_next_lo, cfg_next_hi;

   key_event_type poll_events [$];
   key_event_type pending_events [$];
   poll_row_type  directed_rows [21];

   int  fail_count = 0;
   int  polls_sent = 0;
   int  events_seen = 0;
   int  settings_count = 1;
   int  stall_cycles = 0;
   int  sink_hold_cycles = 0;
   logic src_idles = 1'b1;
   logic sink_idles = 1'b1;

   logic [31:0] stim_ms;
   logic [31:0] stim_raw;
   logic [3:0]  stim_conn;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void reset_model();
      cfg_debounce = bdar_pkg::RST_DEBOUNCE;
      cfg_first_lo = bdar_pkg::RST_INIT_DLY_LOW;
      cfg_first_hi = bdar_pkg::RST_INIT_DLY_HIGH;
      cfg_next_lo  = bdar_pkg::RST_REP_DLY_LOW;
      cfg_next_hi  = bdar_pkg::RST_REP_DLY_HIGH;
      for (int s = 0; s < SLOTS; s++) begin
         key_phase[s] = bdar_pkg::PH_RELEASED;
         settle_timer[s] = '0;
         rep_timer[s] = '0;
      end
      last_poll_ms = '0;
   endfunction

   function automatic logic [15:0] delay_lane(input logic [63:0] lo, input logic [63:0] hi,
                                              input int btn);
      logic [63:0] word;
      word = (btn < 4) ? lo : hi;
      return word[16 * (btn % 4) +: 16];
   endfunction

   function automatic key_event_type key_event(input int slot, input logic rel);
      key_event_type ev;
      ev.pad  = 2'(slot / 8);
      ev.btn  = 3'(slot % 8);
      ev.rel  = rel;
      ev.last = 1'b0;
      return ev;
   endfunction

   // Advance the predicted state by one poll and collect its events
   function automatic void predict_poll(input logic [31:0] poll_ms, input logic [31:0] raw,
                                        input logic [3:0] conn);
      logic [31:0] delta;
      logic [32:0] ct, rt, limit;
      logic [15:0] first_dly, next_dly;
      logic        pressed, fire;
      delta = poll_ms - last_poll_ms;
      limit = 33'(cfg_debounce) + 33'd1;
      poll_events.delete();

      // release pass: debounce every button, emit releases
      for (int s = 0; s < SLOTS; s++) begin
         pressed = conn[s / 8] & raw[s];
         ct = 33'(settle_timer[s]) + 33'(delta);
         rt = 33'(rep_timer[s]) + 33'(delta);
         if (ct > limit) ct = limit;
         if (rt > REPEAT_TIMER_MAX) rt = REPEAT_TIMER_MAX;
         settle_timer[s] = ct[8:0];
         rep_timer[s] = rt[19:0];
         if (pressed != (key_phase[s] != bdar_pkg::PH_RELEASED) &&
             ct > 33'(cfg_debounce)) begin
            settle_timer[s] = '0;
            rep_timer[s] = '0;
            if (pressed) begin
               key_phase[s] = bdar_pkg::PH_NEW;
            end else begin
               key_phase[s] = bdar_pkg::PH_RELEASED;
               poll_events.push_back(key_event(s, 1'b1));
            end
         end
      end
      last_poll_ms = poll_ms;

      // press pass: new presses, first repeat, later repeats
      for (int s = 0; s < SLOTS; s++) begin
         first_dly = delay_lane(cfg_first_lo, cfg_first_hi, s % 8);
         next_dly  = delay_lane(cfg_next_lo, cfg_next_hi, s % 8);
         fire = 1'b0;
         case (key_phase[s])
            bdar_pkg::PH_NEW: begin
               fire = 1'b1;
               rep_timer[s] = '0;
               key_phase[s] = bdar_pkg::PH_ONCE;
            end
            bdar_pkg::PH_ONCE: begin
               if (first_dly != 0 && rep_timer[s] >= 20'(first_dly)) begin
                  fire = 1'b1;
                  rep_timer[s] = rep_timer[s] - 20'(first_dly);
                  key_phase[s] = bdar_pkg::PH_REPEAT;
               end
            end
            bdar_pkg::PH_REPEAT: begin
               if (next_dly != 0 && rep_timer[s] >= 20'(next_dly)) begin
                  fire = 1'b1;
                  rep_timer[s] = rep_timer[s] - 20'(next_dly);
               end
            end
            default: ;
         endcase
         if (fire) poll_events.push_back(key_event(s, 1'b0));
      end
      if (poll_events.size() != 0) poll_events[poll_events.size() - 1].last = 1'b1;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int idle_gap(input logic enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] pick_delay_word();
      logic [63:0] word;
      int r;
      for (int k = 0; k < 4; k++) begin
         r = $urandom_range(0, 99);
         if (r < 15)      word[16*k +: 16] = '0;
         else if (r < 85) word[16*k +: 16] = 16'($urandom_range(1, 60));
         else if (r < 95) word[16*k +: 16] = 16'($urandom_range(61, 600));
         else             word[16*k +: 16] = 16'($urandom);
      end
      return word;
   endfunction

   // Offer one poll, predict its events once the transfer is certain
   task automatic send_poll(input logic [31:0] poll_ms, input logic [31:0] raw,
                            input logic [3:0] conn, input row_check_type chk,
                            input key_event_type typed);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.now_ms      <= poll_ms;
      req_ch.raw_pressed <= raw;
      req_ch.connected   <= conn;
      do @(negedge clock); while (req_ch.ready !== 1'b1);
      predict_poll(poll_ms, raw, conn);
      case (chk)
         CHK_MODEL: foreach (poll_events[i]) pending_events.push_back(poll_events[i]);
         CHK_ONE:   pending_events.push_back(typed);
         default: ;
      endcase
      polls_sent++;
      @(posedge clock);
      gap = idle_gap(src_idles);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the poll channel until every predicted event has come out
   task automatic drain_events();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bdar_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         bdar_pkg::CSR_DEBOUNCE:      cfg_debounce = value[7:0];
         bdar_pkg::CSR_INIT_DLY_LOW:  cfg_first_lo = value;
         bdar_pkg::CSR_INIT_DLY_HIGH: cfg_first_hi = value;
         bdar_pkg::CSR_REP_DLY_LOW:   cfg_next_lo = value;
         bdar_pkg::CSR_REP_DLY_HIGH:  cfg_next_hi = value;
         default: ;
      endcase
   endtask

   // Let the unit go idle, then load a full register set
   task automatic reconfigure(input logic [7:0] debounce, input logic [63:0] first_lo,
                              input logic [63:0] first_hi, input logic [63:0] next_lo,
                              input logic [63:0] next_hi);
      drain_events();
      // a poll with no events may still be walking
      repeat (POLL_CYCLES + 10) @(posedge clock);
      write_csr(bdar_pkg::CSR_DEBOUNCE, {32'($urandom), 24'($urandom), debounce});
      write_csr(bdar_pkg::CSR_INIT_DLY_LOW, first_lo);
      write_csr(bdar_pkg::CSR_INIT_DLY_HIGH, first_hi);
      write_csr(bdar_pkg::CSR_REP_DLY_LOW, next_lo);
      write_csr(bdar_pkg::CSR_REP_DLY_HIGH, next_hi);
      settings_count++;
   endtask

   // Random polls: mostly small time steps with sticky buttons and bounces
   task automatic random_polls(input int count);
      logic [31:0] step;
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 60)      step = $urandom_range(0, 30);
         else if (r < 85) step = $urandom_range(31, 400);
         else if (r < 95) step = $urandom_range(401, 70000);
         else             step = $urandom;
         stim_ms += step;
         r = $urandom_range(0, 99);
         if (r < 25)      stim_raw[$urandom_range(0, SLOTS - 1)] ^= 1'b1;
         else if (r < 33) stim_raw ^= $urandom;
         else if (r < 36) stim_raw = ~stim_raw;
         r = $urandom_range(0, 99);
         if (r < 8)       stim_conn = 4'($urandom);
         else if (r < 12) stim_conn = 4'hF;
         send_poll(stim_ms, stim_raw, stim_conn, CHK_MODEL, '0);
         if ($urandom_range(0, 39) == 0) drain_events();
      end
   endtask

   // Event side: random ready stalls, plus one long hold-off on request
   initial begin : event_sink
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         gap = idle_gap(sink_idles);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Compare each event transfer with the oldest prediction
   always @(negedge clock) begin : event_check
      key_event_type exp_ev;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         events_seen++;
         if (pending_events.size() == 0) begin
            $error("event with nothing predicted: pad %0d button %0d release %0d",
                   rsp_ch.pad_index, rsp_ch.button_index, rsp_ch.is_release);
            fail_count++;
         end else begin
            exp_ev = pending_events.pop_front();
            if (rsp_ch.pad_index !== exp_ev.pad) begin
               $error("pad_index: expected %0d, got %0d", exp_ev.pad, rsp_ch.pad_index);
               fail_count++;
            end
            if (rsp_ch.button_index !== exp_ev.btn) begin
               $error("button_index: expected %0d, got %0d", exp_ev.btn, rsp_ch.button_index);
               fail_count++;
            end
            if (rsp_ch.is_release !== exp_ev.rel) begin
               $error("is_release: expected %0d, got %0d", exp_ev.rel, rsp_ch.is_release);
               fail_count++;
            end
            if (rsp_ch.last_event !== exp_ev.last) begin
               $error("last_event: expected %0d, got %0d", exp_ev.last, rsp_ch.last_event);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(negedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d events outstanding",
                     stall_cycles, pending_events.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      key_event_type ev;
      reset_model();
      req_ch.valid       <= 1'b0;
      req_ch.now_ms      <= '0;
      req_ch.raw_pressed <= '0;
      req_ch.connected   <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= bdar_pkg::CSR_DEBOUNCE;
      csr_wdata          <= '0;

      // Corner cases at reset settings: debounce 20, delays from reset values
      directed_rows = '{
         '{32'h0000_0000, 32'hFFFF_FFFF, 4'hF, CHK_QUIET, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0015, 32'h0000_0001, 4'h1, CHK_ONE,   2'd0, BTN_B, 1'b0},
         '{32'h0000_0030, 32'h0000_0001, 4'h1, CHK_QUIET, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0224, 32'h0000_0001, 4'h1, CHK_ONE,   2'd0, BTN_B, 1'b0},
         '{32'h0000_0224, 32'h0000_0000, 4'h1, CHK_ONE,   2'd0, BTN_B, 1'b1},
         // every button at once, then time wraps past zero
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, CHK_MODEL, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0010, 32'h0000_0000, 4'hF, CHK_QUIET, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0020, 32'h0000_0000, 4'hF, CHK_MODEL, 2'd0, BTN_B, 1'b0},
         // two pads connected, long hold builds a repeat backlog
         '{32'h0000_0040, 32'hFFFF_FFFF, 4'h5, CHK_MODEL, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0428, 32'hFFFF_FFFF, 4'h5, CHK_MODEL, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0428, 32'hFFFF_FFFF, 4'h5, CHK_MODEL, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0428, 32'hFFFF_FFFF, 4'h5, CHK_MODEL, 2'd0, BTN_B, 1'b0},
         // all pads unplugged while held
         '{32'h0000_0428, 32'hFFFF_FFFF, 4'h0, CHK_MODEL, 2'd0, BTN_B, 1'b0},
         '{32'h0000_0428, 32'h8000_0000, 4'h8, CHK_ONE,   2'd3, BTN_LEFT, 1'b0},
         // short bounce is ignored
         '{32'h0000_042D, 32'h0000_0000, 4'h8, CHK_QUIET, 2'd3, BTN_LEFT, 1'b0},
         '{32'h0000_04F0, 32'h8000_0000, 4'h8, CHK_ONE,   2'd3, BTN_LEFT, 1'b0},
         '{32'h0000_0503, 32'h8000_0000, 4'h8, CHK_QUIET, 2'd3, BTN_LEFT, 1'b0},
         '{32'h0000_0504, 32'h8000_0000, 4'h8, CHK_ONE,   2'd3, BTN_LEFT, 1'b0},
         // huge step saturates the repeat timer
         '{32'h8000_0504, 32'h8000_0000, 4'h8, CHK_ONE,   2'd3, BTN_LEFT, 1'b0},
         '{32'h8000_0504, 32'h8000_0000, 4'h8, CHK_MODEL, 2'd3, BTN_LEFT, 1'b0},
         '{32'h8000_0504, 32'h0000_0000, 4'hF, CHK_ONE,   2'd3, BTN_LEFT, 1'b1}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         ev.pad  = directed_rows[i].pad;
         ev.btn  = directed_rows[i].btn;
         ev.rel  = directed_rows[i].rel;
         ev.last = 1'b1;
         send_poll(directed_rows[i].poll_ms, directed_rows[i].raw, directed_rows[i].conn,
                   directed_rows[i].chk, ev);
      end
      stim_ms   = 32'h8000_0504;
      stim_raw  = '0;
      stim_conn = 4'hF;

      // no debounce, short delays
      reconfigure(8'd0, pick_delay_word(), pick_delay_word(), pick_delay_word(),
                  pick_delay_word());
      random_polls(80);

      // slowest settings: full debounce, longest delays
      reconfigure(8'hFF, '1, '1, '1, '1);
      random_polls(50);

      // drop the threshold under saturated change timers, then stall the event side
      reconfigure(8'd3, pick_delay_word(), pick_delay_word(), pick_delay_word(),
                  pick_delay_word());
      write_csr(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), {$urandom, $urandom});
      sink_hold_cycles = HOLD_OFF_CYCLES;
      stim_raw = ~stim_raw;
      stim_ms += 32'd500;
      stim_conn = 4'hF;
      random_polls(80);

      // repeats disabled everywhere
      reconfigure(8'($urandom_range(0, 40)), '0, '0, '0, '0);
      random_polls(60);

      // mixed delays and back-to-back transfers on both sides
      reconfigure(8'($urandom_range(0, 12)), pick_delay_word(), {$urandom, $urandom},
                  pick_delay_word(), pick_delay_word());
      src_idles = 1'b0;
      sink_idles = 1'b0;
      random_polls(70);
      src_idles = 1'b1;
      sink_idles = 1'b1;
      random_polls(70);

      drain_events();
      repeat (POLL_CYCLES + 10) @(posedge clock);

      $display("Ran %0d polls (%0d from the corner-case table) over %0d register settings,",
               polls_sent, $size(directed_rows), settings_count);
      $display("checked %0d button events, including a %0d-cycle stall on the event side.",
               events_seen, HOLD_OFF_CYCLES);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== button_debounce_autorepeat_unit.f =====
src/bdar_pkg.sv
src/bdar_req_if.sv
src/bdar_rsp_if.sv
src/bdar_ram.sv
src/bdar_slot_unit.sv
src/button_debounce_autorepeat_unit.sv
tb/button_debounce_autorepeat_unit_tb.sv
